// ===== src/nsbc_pkg.sv =====
// Package: cipher constants, S-boxes and round functions.
`default_nettype none
package nsbc_pkg;

  localparam int NIBBLES = 16;

  localparam logic [63:0] KEY_RESET = 64'h7693_1FAC_9DAB_2B36;
  // Key tweak: nibbles 12 and 15 get 0xf, nibbles 13 and 14 get 0x3
  localparam logic [63:0] KEY_TWEAK = 64'h0000_0000_0000_F33F;

  localparam logic ACT_ENCRYPT = 1'b0;
  localparam logic ACT_DECRYPT = 1'b1;

  localparam logic [3:0] FWD_BOX [NIBBLES] = '{
    4'ha, 4'h5, 4'h4, 4'h2, 4'h6, 4'h1, 4'hf, 4'h3,
    4'hb, 4'he, 4'h7, 4'h0, 4'h8, 4'hd, 4'hc, 4'h9
  };
  localparam logic [3:0] INV_BOX [NIBBLES] = '{
    4'hb, 4'h5, 4'h3, 4'h7, 4'h2, 4'h1, 4'h4, 4'ha,
    4'hc, 4'hf, 4'h0, 4'h8, 4'he, 4'hd, 4'h9, 4'h6
  };

  typedef logic [63:0] block_t;

  // Nibble i sits at bits 63-4i downto 60-4i
  function automatic logic [3:0] nib(input block_t x, input int i);
    nib = x[63-4*i -: 4];
  endfunction

  function automatic block_t next_key(input block_t k);
    block_t t;
    t = k ^ KEY_TWEAK;
    next_key = {t[15:0], t[63:16]};
  endfunction

  function automatic block_t sub_fwd(input block_t x);
    block_t t;
    for (int i = 0; i < NIBBLES; i++) begin
      t[63-4*i -: 4] = FWD_BOX[nib(x, i)];
    end
    sub_fwd = t;
  endfunction

  function automatic block_t sub_inv(input block_t x);
    block_t t;
    for (int i = 0; i < NIBBLES; i++) begin
      t[63-4*i -: 4] = INV_BOX[nib(x, i)];
    end
    sub_inv = t;
  endfunction

  // Row r rotated left (left=1) or right (left=0) by r nibbles
  function automatic block_t rotate_rows(input block_t x, input logic left);
    block_t t;
    int src;
    for (int r = 0; r < 4; r++) begin
      for (int c = 0; c < 4; c++) begin
        src = left ? ((c + r) & 3) : ((c - r + 4) & 3);
        t[63-4*(4*r+c) -: 4] = nib(x, 4*r + src);
      end
    end
    rotate_rows = t;
  endfunction

  function automatic block_t mix(input block_t x);
    logic [15:0] r0, r1, r2, r3;
    r0 = x[63:48];
    r1 = x[47:32];
    r2 = x[31:16];
    r3 = x[15:0];
    mix = {r0 ^ r2, r1 ^ r2, r0, r2 ^ r3};
  endfunction

  function automatic block_t unmix(input block_t x);
    logic [15:0] r0, r1, r2, r3;
    r0 = x[63:48];
    r1 = x[47:32];
    r2 = x[31:16];
    r3 = x[15:0];
    unmix = {r2, r0 ^ r1 ^ r2, r0 ^ r2, r0 ^ r2 ^ r3};
  endfunction

  function automatic block_t enc_round(input block_t x, input block_t k);
    enc_round = mix(rotate_rows(sub_fwd(x ^ {32'h0, k[31:0]}), 1'b1));
  endfunction

  function automatic block_t dec_round(input block_t x, input block_t k);
    dec_round = sub_inv(rotate_rows(unmix(x), 1'b0)) ^ {32'h0, k[31:0]};
  endfunction

endpackage
`default_nettype wire

// ===== src/nsbc_in_if.sv =====
// Interface: input channel (action and block).
`default_nettype none
interface nsbc_in_if;
  logic        valid;
  logic        ready;
  logic        action;
  logic [63:0] data_in;

  modport source (output valid, output action, output data_in, input ready);
  modport sink (input valid, input action, input data_in, output ready);
endinterface
`default_nettype wire

// ===== src/nsbc_out_if.sv =====
// Interface: result channel (processed block).
`default_nettype none
interface nsbc_out_if;
  logic        valid;
  logic        ready;
  logic [63:0] data_out;

  modport source (output valid, output data_out, input ready);
  modport sink (input valid, input data_out, output ready);
endinterface
`default_nettype wire

// ===== src/nibble_spn_block_cipher.sv =====
// Top level: nibble SPN block cipher, fully unrolled between two register stages.
`default_nettype none
// Encrypts or decrypts one 64-bit block per cycle. A beat is captured in an
// input register, all ROUNDS rounds are evaluated in one combinational pass
// (round keys come straight from the key register through fixed XORs and
// rotations), and the result lands in the output register. One beat per cycle is
// sustained for as long as the result side takes beats. The input stage advances
// only when the output stage can take its result, so a new beat is taken while a
// finished result waits only if the input register is empty. The key register is
// written through cfg_we/cfg_data and must only change while the block is idle.
module nibble_spn_block_cipher #(
  parameter int ROUNDS = 4
) (
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire logic        cfg_we,
  input  wire logic [63:0] cfg_data,
  nsbc_in_if.sink          blk_in,
  nsbc_out_if.source       blk_out
);

  logic [63:0] cipher_key;

  logic        in_valid;
  logic        in_action;
  logic [63:0] in_data;
  logic        in_ready;

  logic        out_valid;
  logic [63:0] out_data;
  logic        out_ready;

  logic [63:0] sched_key [ROUNDS];
  logic [63:0] enc_x [ROUNDS+1];
  logic [63:0] dec_x [ROUNDS+1];
  logic [63:0] result;

  always_ff @(posedge clk) begin
    if (rst) begin
      cipher_key <= nsbc_pkg::KEY_RESET;
    end else if (cfg_we) begin
      cipher_key <= cfg_data;
    end
  end

  // Round key schedule
  assign sched_key[0] = cipher_key;
  for (genvar r = 1; r < ROUNDS; r++) begin : g_key
    assign sched_key[r] = nsbc_pkg::next_key(sched_key[r-1]);
  end

  // Encrypt uses keys in order, decrypt in reverse order
  assign enc_x[0] = in_data;
  assign dec_x[0] = in_data;
  for (genvar r = 0; r < ROUNDS; r++) begin : g_round
    assign enc_x[r+1] = nsbc_pkg::enc_round(enc_x[r], sched_key[r]);
    assign dec_x[r+1] = nsbc_pkg::dec_round(dec_x[r], sched_key[ROUNDS-1-r]);
  end

  assign result = (in_action == nsbc_pkg::ACT_DECRYPT) ? dec_x[ROUNDS] : enc_x[ROUNDS];

  assign out_ready    = !out_valid || blk_out.ready;
  assign in_ready     = !in_valid || out_ready;
  assign blk_in.ready = in_ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      in_valid <= 1'b0;
    end else if (in_ready) begin
      in_valid <= blk_in.valid;
    end
  end

  always_ff @(posedge clk) begin
    if (blk_in.valid && in_ready) begin
      in_action <= blk_in.action;
      in_data   <= blk_in.data_in;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (out_ready) begin
      out_valid <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && out_ready) begin
      out_data <= result;
    end
  end

  assign blk_out.valid    = out_valid;
  assign blk_out.data_out = out_data;

endmodule
`default_nettype wire
